### hw/rtl/psc_pkg.sv
// Shared types for the point set correlation block: status codes,
// controller states, multiply operations and the control/status structs.
// No dependencies.
`default_nettype none

package psc_pkg;

   localparam int STATUS_W = 2;
   localparam int MUL_OP_W = 3;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_SPREAD   = 2'd2,
      STAT_OVERFLOW = 2'd3
   } status_type;

   // N*Sxx, Sx*Sx, N*Syy, Sy*Sy, N*Sxy, Sx*Sy, vx*vy, cov*cov
   typedef enum logic [MUL_OP_W-1:0] {
      MOP_NXX,
      MOP_SXX,
      MOP_NYY,
      MOP_SYY,
      MOP_NXY,
      MOP_SXY,
      MOP_VV,
      MOP_CC
   } mul_op_type;

   typedef enum logic [2:0] {
      CS_ACCUM,
      CS_CHECK,
      CS_MUL_RUN,
      CS_MUL_STORE,
      CS_DIV_RUN,
      CS_SQRT_RUN,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       accept;
      logic       clear;
      logic       mul_start;
      mul_op_type start_op;
      logic       mul_store;
      mul_op_type store_op;
      logic       div_start;
      logic       sqrt_start;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic overflow;
      logic count_zero;
      logic spread_zero;
      logic mul_busy;
      logic div_busy;
      logic sqrt_busy;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

### hw/rtl/psc_ifs.sv
// Valid/ready channel interfaces for the point set correlation block:
// point input channel and correlation result channel.
// Depends on psc_pkg.
`default_nettype none

interface psc_req_if #(
   parameter int COORD_BITS = 12
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic                  last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface psc_rsp_if import psc_pkg::*; #(
   parameter int FRAC_BITS = 16
) ();
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   corr_value;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, corr_value, status, input ready);
   modport sink   (input valid, corr_value, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/psc_ctrl.sv
// Controller for the point set correlation block: sequences accumulation,
// the eight shared multiplies, the divide, the square root and the output load.
// Depends on psc_pkg.
`default_nettype none

module psc_ctrl import psc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   mul_op_type     op_ff, op_in;
   logic           accept;

   assign req_ready = (state_ff == CS_ACCUM);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         CS_ACCUM: begin
            if (accept && req_last) state_in = CS_CHECK;
         end
         CS_CHECK: begin
            if (stat.overflow || stat.count_zero) begin
               state_in = CS_DONE;
            end else begin
               state_in = CS_MUL_RUN;
               op_in    = MOP_NXX;
            end
         end
         CS_MUL_RUN: begin
            if (!stat.mul_busy) state_in = CS_MUL_STORE;
         end
         CS_MUL_STORE: begin
            if (op_ff == MOP_CC) begin
               state_in = stat.spread_zero ? CS_DONE : CS_DIV_RUN;
            end else begin
               state_in = CS_MUL_RUN;
               op_in    = mul_op_type'(op_ff + MUL_OP_W'(1));
            end
         end
         CS_DIV_RUN: begin
            if (!stat.div_busy) state_in = CS_SQRT_RUN;
         end
         CS_SQRT_RUN: begin
            if (!stat.sqrt_busy) state_in = CS_DONE;
         end
         CS_DONE: begin
            if (stat.out_free) state_in = CS_ACCUM;
         end
         default: begin
            state_in = CS_ACCUM;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.start_op = op_in;
      cmd.store_op = op_ff;
      case (state_ff)
         CS_CHECK: begin
            cmd.mul_start = !(stat.overflow || stat.count_zero);
         end
         CS_MUL_STORE: begin
            cmd.mul_store = 1'b1;
            if (op_ff == MOP_CC) begin
               cmd.div_start = !stat.spread_zero;
            end else begin
               cmd.mul_start = 1'b1;
            end
         end
         CS_DIV_RUN: begin
            cmd.sqrt_start = !stat.div_busy;
         end
         CS_DONE: begin
            cmd.out_load = stat.out_free;
            cmd.clear    = stat.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_ACCUM;
         op_ff    <= MOP_NXX;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/psc_dp.sv
// Datapath for the point set correlation block: accumulators, shift-add
// multiplier, restoring divider, digit-by-digit square root, result register.
// Depends on psc_pkg.
`default_nettype none

module psc_dp import psc_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FRAC_BITS:0]    corr_value,
   output logic [STATUS_W-1:0]   status
);

   localparam int LG_W   = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SUM_W  = COORD_BITS + LG_W;
   localparam int SQ_W   = 2 * COORD_BITS + LG_W;
   localparam int VW     = CNT_W + SQ_W;
   localparam int PW     = 2 * VW;
   localparam int QW     = 2 * FRAC_BITS + 1;
   localparam int RW     = FRAC_BITS + 1;
   localparam int MCNT_W = $clog2(VW);
   localparam int DCNT_W = $clog2(QW);
   localparam int SCNT_W = $clog2(RW);

   // ---------------- accumulators ----------------
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SUM_W-1:0]        sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [SQ_W-1:0]         sum_xx_ff, sum_xx_in, sum_yy_ff, sum_yy_in, sum_xy_ff, sum_xy_in;
   logic                    ovf_ff, ovf_in;
   logic [2*COORD_BITS-1:0] xx, yy, xy;

   assign xx = point_x * point_x;
   assign yy = point_y * point_y;
   assign xy = point_x * point_y;

   always_comb begin
      count_in  = count_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xx_in = sum_xx_ff;
      sum_yy_in = sum_yy_ff;
      sum_xy_in = sum_xy_ff;
      ovf_in    = ovf_ff;
      if (cmd.clear) begin
         count_in  = '0;
         sum_x_in  = '0;
         sum_y_in  = '0;
         sum_xx_in = '0;
         sum_yy_in = '0;
         sum_xy_in = '0;
         ovf_in    = 1'b0;
      end else if (cmd.accept) begin
         if (count_ff < CNT_W'(MAX_POINTS)) begin
            count_in  = count_ff + CNT_W'(1);
            sum_x_in  = sum_x_ff + SUM_W'(point_x);
            sum_y_in  = sum_y_ff + SUM_W'(point_y);
            sum_xx_in = sum_xx_ff + SQ_W'(xx);
            sum_yy_in = sum_yy_ff + SQ_W'(yy);
            sum_xy_in = sum_xy_ff + SQ_W'(xy);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_yy_ff <= '0;
         sum_xy_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xx_ff <= sum_xx_in;
         sum_yy_ff <= sum_yy_in;
         sum_xy_ff <= sum_xy_in;
         ovf_ff    <= ovf_in;
      end
   end

   // ---------------- shared shift-add multiplier ----------------
   logic [VW-1:0]     mop_a, mop_b;
   logic [VW-1:0]     mcand_ff, mcand_in;
   logic [PW-1:0]     prod_ff, prod_in;
   logic [MCNT_W-1:0] mcnt_ff, mcnt_in;
   logic              mbusy_ff, mbusy_in;
   logic [VW:0]       madd;
   logic [VW-1:0]     tmp_ff, tmp_in, vx_ff, vx_in, vy_ff, vy_in, cov_ff, cov_in;
   logic [PW-1:0]     v_ff, v_in;

   always_comb begin
      case (cmd.start_op)
         MOP_NXX: begin mop_a = VW'(count_ff); mop_b = VW'(sum_xx_ff); end
         MOP_SXX: begin mop_a = VW'(sum_x_ff); mop_b = VW'(sum_x_ff);  end
         MOP_NYY: begin mop_a = VW'(count_ff); mop_b = VW'(sum_yy_ff); end
         MOP_SYY: begin mop_a = VW'(sum_y_ff); mop_b = VW'(sum_y_ff);  end
         MOP_NXY: begin mop_a = VW'(count_ff); mop_b = VW'(sum_xy_ff); end
         MOP_SXY: begin mop_a = VW'(sum_x_ff); mop_b = VW'(sum_y_ff);  end
         MOP_VV:  begin mop_a = vx_ff;         mop_b = vy_ff;          end
         MOP_CC:  begin mop_a = cov_ff;        mop_b = cov_ff;         end
         default: begin mop_a = '0;            mop_b = '0;             end
      endcase
   end

   assign madd = {1'b0, prod_ff[PW-1:VW]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);

   always_comb begin
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      mcnt_in  = mcnt_ff;
      mbusy_in = mbusy_ff;
      if (cmd.mul_start) begin
         mcand_in = mop_a;
         prod_in  = {VW'(0), mop_b};
         mcnt_in  = '0;
         mbusy_in = 1'b1;
      end else if (mbusy_ff) begin
         prod_in = {madd, prod_ff[VW-1:1]};
         mcnt_in = mcnt_ff + MCNT_W'(1);
         if (mcnt_ff == MCNT_W'(VW - 1)) mbusy_in = 1'b0;
      end
   end

   // products are nonnegative differences of N*S and S*S; cov takes the magnitude
   logic [VW-1:0] plow, pdiff, ndiff;
   assign plow  = prod_ff[VW-1:0];
   assign pdiff = tmp_ff - plow;
   assign ndiff = plow - tmp_ff;

   always_comb begin
      tmp_in = tmp_ff;
      vx_in  = vx_ff;
      vy_in  = vy_ff;
      cov_in = cov_ff;
      v_in   = v_ff;
      if (cmd.mul_store) begin
         case (cmd.store_op)
            MOP_NXX, MOP_NYY, MOP_NXY: tmp_in = plow;
            MOP_SXX: vx_in  = pdiff;
            MOP_SYY: vy_in  = pdiff;
            MOP_SXY: cov_in = (tmp_ff >= plow) ? pdiff : ndiff;
            MOP_VV:  v_in   = prod_ff;
            default: begin
            end
         endcase
      end
   end

   // ---------------- restoring divider: Q = (cov^2 << 2F) / (vx*vy) ----------------
   logic [PW-1:0]     rem_ff, rem_in;
   logic              din_ff, din_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              dbusy_ff, dbusy_in;
   logic [PW:0]       dsh;
   logic [PW+1:0]     dsub;
   logic              dge;

   assign dsh  = {rem_ff, din_ff};
   assign dsub = {1'b0, dsh} - {2'b00, v_ff};
   assign dge  = !dsub[PW+1];

   always_comb begin
      rem_in   = rem_ff;
      din_in   = din_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      dbusy_in = dbusy_ff;
      if (cmd.div_start) begin
         rem_in   = {1'b0, prod_ff[PW-1:1]};
         din_in   = prod_ff[0];
         quo_in   = '0;
         dcnt_in  = '0;
         dbusy_in = 1'b1;
      end else if (dbusy_ff) begin
         rem_in  = dge ? dsub[PW-1:0] : dsh[PW-1:0];
         din_in  = 1'b0;
         quo_in  = {quo_ff[QW-2:0], dge};
         dcnt_in = dcnt_ff + DCNT_W'(1);
         if (dcnt_ff == DCNT_W'(QW - 1)) dbusy_in = 1'b0;
      end
   end

   // ---------------- integer square root, one result bit per cycle ----------------
   logic [2*RW-1:0]   sop_ff, sop_in;
   logic [RW:0]       srem_ff, srem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic              sbusy_ff, sbusy_in;
   logic [RW+1:0]     s4, strial;
   logic [RW+2:0]     ssub;
   logic              sge;

   assign s4     = {srem_ff[RW-1:0], sop_ff[2*RW-1 -: 2]};
   assign strial = {1'b0, root_ff[RW-2:0], 2'b01};
   assign ssub   = {1'b0, s4} - {1'b0, strial};
   assign sge    = !ssub[RW+2];

   always_comb begin
      sop_in   = sop_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      scnt_in  = scnt_ff;
      sbusy_in = sbusy_ff;
      if (cmd.sqrt_start) begin
         sop_in   = {1'b0, quo_ff};
         srem_in  = '0;
         root_in  = '0;
         scnt_in  = '0;
         sbusy_in = 1'b1;
      end else if (sbusy_ff) begin
         sop_in  = {sop_ff[2*RW-3:0], 2'b00};
         srem_in = sge ? ssub[RW:0] : s4[RW:0];
         root_in = {root_ff[RW-2:0], sge};
         scnt_in = scnt_ff + SCNT_W'(1);
         if (scnt_ff == SCNT_W'(RW - 1)) sbusy_in = 1'b0;
      end
   end

   // ---------------- result register ----------------
   status_type      status_sel;
   status_type      status_ff, status_in;
   logic [RW-1:0]   corr_ff, corr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            spread_zero;

   assign spread_zero = (vx_ff == '0) || (vy_ff == '0);

   always_comb begin
      if (ovf_ff) begin
         status_sel = STAT_OVERFLOW;
      end else if (count_ff == '0) begin
         status_sel = STAT_EMPTY;
      end else if (spread_zero) begin
         status_sel = STAT_SPREAD;
      end else begin
         status_sel = STAT_OK;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      corr_in      = corr_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         status_in    = status_sel;
         corr_in      = (status_sel == STAT_OK) ? root_ff : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff     <= 1'b0;
         dbusy_ff     <= 1'b0;
         sbusy_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mbusy_ff     <= mbusy_in;
         dbusy_ff     <= dbusy_in;
         sbusy_ff     <= sbusy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      mcnt_ff   <= mcnt_in;
      tmp_ff    <= tmp_in;
      vx_ff     <= vx_in;
      vy_ff     <= vy_in;
      cov_ff    <= cov_in;
      v_ff      <= v_in;
      rem_ff    <= rem_in;
      din_ff    <= din_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      sop_ff    <= sop_in;
      srem_ff   <= srem_in;
      root_ff   <= root_in;
      scnt_ff   <= scnt_in;
      status_ff <= status_in;
      corr_ff   <= corr_in;
   end

   assign stat.overflow    = ovf_ff;
   assign stat.count_zero  = (count_ff == '0);
   assign stat.spread_zero = spread_zero;
   assign stat.mul_busy    = mbusy_ff;
   assign stat.div_busy    = dbusy_ff;
   assign stat.sqrt_busy   = sbusy_ff;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign corr_value = corr_ff;
   assign status     = status_ff;

endmodule

`default_nettype wire

### hw/rtl/point_set_correlation.sv
// Absolute Pearson correlation of a point set, valid/ready in and out.
// Points (point_x, point_y, last_point) arrive on req_if, one transfer per point.
// While a set accumulates, a point is taken every cycle (ready held high).
// The transfer with last_point set closes the set: ready drops and the block
// computes |N*Sxy - Sx*Sy| / sqrt((N*Sxx - Sx^2)(N*Syy - Sy^2)) exactly,
// truncated to FRAC_BITS fraction bits, with one shared shift-add multiplier
// (eight products of VW-bit operands), a restoring divider and a square root.
// VW = clog2(MAX_POINTS+1) + 2*COORD_BITS + clog2(MAX_POINTS).
// A set that overflowed or is empty skips the arithmetic.
// A result sits in an output register on rsp_if until taken; points of the
// next set are accepted meanwhile. If the receiver still holds the previous
// result when the next one is ready, the block waits with ready low.
// Reset (synchronous) clears all sums, the point count and the output valid.
// Depends on psc_pkg, psc_ifs, psc_ctrl and psc_dp.
`default_nettype none

module point_set_correlation import psc_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int MAX_POINTS = 1024,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   psc_req_if.sink    req_if,
   psc_rsp_if.source  rsp_if
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   psc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_point),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psc_dp #(
      .COORD_BITS (COORD_BITS),
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .point_x    (req_if.point_x),
      .point_y    (req_if.point_y),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .corr_value (rsp_if.corr_value),
      .status     (rsp_if.status)
   );

`ifndef SYNTHESIS
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !stat.mul_busy)
      else $error("multiply started while multiplier busy");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result overwritten before transfer");

   a_last_stall: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && req_if.last_point) |=> !req_if.ready)
      else $error("point accepted right after end of set");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != STAT_OK) |-> (rsp_if.corr_value == '0))
      else $error("nonzero value with error status");
`endif

endmodule

`default_nettype wire
